[hdl/swdh_pkg.sv]
// Package for the SWD host transfer engine: transaction payload types, engine state,
// phase/ack/status codes and the request packet builder.
// No dependencies; compiled first.
package swdh_pkg;

    // Register defaults after reset
    localparam logic [7:0] RETRY_LIMIT_RST = 8'd20;
    localparam logic [7:0] IDLE_CYCLES_RST = 8'd8;

    // Configuration register indexes
    localparam logic CFG_RETRY_LIMIT = 1'b0;
    localparam logic CFG_IDLE_CYCLES = 1'b1;

    // Command modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_LRST  = 2'd2;

    // Engine phases
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_REQ  = 4'd1;
    localparam logic [3:0] PH_TRN  = 4'd2;
    localparam logic [3:0] PH_ACK  = 4'd3;
    localparam logic [3:0] PH_ATRN = 4'd4;
    localparam logic [3:0] PH_RDAT = 4'd5;
    localparam logic [3:0] PH_RPAR = 4'd6;
    localparam logic [3:0] PH_WTRN = 4'd7;
    localparam logic [3:0] PH_WDAT = 4'd8;
    localparam logic [3:0] PH_WPAR = 4'd9;
    localparam logic [3:0] PH_IDLZ = 4'd10;
    localparam logic [3:0] PH_LRST = 4'd11;

    // Acknowledge codes (LSB received first)
    localparam logic [2:0] ACK_OK    = 3'd1;
    localparam logic [2:0] ACK_WAIT  = 3'd2;
    localparam logic [2:0] ACK_FAULT = 3'd4;

    // Completion status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_FAULT   = 3'd2;
    localparam logic [2:0] ST_NOCONN  = 3'd3;
    localparam logic [2:0] ST_PARITY  = 3'd4;

    // Line reset sequence: ones, select pattern, ones
    localparam logic [15:0] LINE_SEQ      = 16'hE79E;
    localparam logic [7:0]  LRST_SEQ_LO   = 8'd64;
    localparam logic [7:0]  LRST_SEQ_HI   = 8'd80;
    localparam logic [7:0]  LRST_LEN      = 8'd144;
    localparam logic [7:0]  REQ_LEN       = 8'd8;
    localparam logic [7:0]  ACK_LEN       = 8'd3;
    localparam logic [7:0]  DATA_LEN      = 8'd32;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  request_bits;
        logic [31:0] write_data;
        logic        swdio_in;
    } t_cmd;

    typedef struct packed {
        logic        swdio_out;
        logic        swdio_drive;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  status;
        logic [31:0] read_data;
    } t_rsp;

    typedef struct packed {
        logic [7:0] retry_limit;
        logic [7:0] idle_cycles;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  bit_count;
        logic [31:0] shift_word;
        logic [3:0]  held_request;
        logic [7:0]  retries_left;
        logic [2:0]  ack_bits;
        logic        parity_acc;
        logic [2:0]  final_status;
    } t_state;

    // Request packet: start, APnDP, RnW, A2, A3, parity, stop, park (LSB first)
    function automatic logic [7:0] req_packet(input logic [3:0] r);
        logic p;
        p = ^r;
        return {1'b1, 1'b0, p, r, 1'b1};
    endfunction

endpackage

[hdl/swdh_chan_if.sv]
// Valid/ready channel interface carrying one payload per transaction.
// Payload type is a parameter; used with swdh_pkg types.
interface swdh_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/swdh_step.sv]
// One SWD engine step: next state and result for one command transaction.
// Pure combinational logic; depends on swdh_pkg.
module swdh_step
    import swdh_pkg::*;
(
    input  t_state i_state,
    input  t_cmd   i_cmd,
    input  t_cfg   i_cfg,
    output t_state o_state,
    output t_rsp   o_rsp
);

    logic        bit_o;
    logic        drv;
    logic        busy;
    logic        fin;
    logic        rd_valid;
    logic [2:0]  ack_n;
    logic [7:0]  cnt_inc;
    logic [7:0]  pkt;
    t_state      s;

    always_comb begin
        s        = i_state;
        bit_o    = 1'b0;
        drv      = 1'b0;
        busy     = 1'b0;
        fin      = 1'b0;
        rd_valid = 1'b0;
        cnt_inc  = i_state.bit_count + 8'd1;
        pkt      = req_packet(i_state.held_request);
        ack_n    = i_state.ack_bits;

        if (i_cmd.mode != MODE_TICK) begin
            // start and line-reset commands are taken only while idle
            if (i_state.phase == PH_IDLE && i_cmd.mode == MODE_START) begin
                s.held_request = i_cmd.request_bits;
                s.shift_word   = i_cmd.write_data;
                s.retries_left = (i_cfg.retry_limit == 8'd0) ? 8'd1 : i_cfg.retry_limit;
                s.final_status = ST_OK;
                s.bit_count    = 8'd0;
                s.phase        = PH_REQ;
            end else if (i_state.phase == PH_IDLE && i_cmd.mode == MODE_LRST) begin
                s.final_status = ST_OK;
                s.bit_count    = 8'd0;
                s.phase        = PH_LRST;
            end
            busy = (s.phase != PH_IDLE);
        end else if (i_state.phase != PH_IDLE) begin
            busy = 1'b1;
            case (i_state.phase)
                PH_REQ: begin
                    drv         = 1'b1;
                    bit_o       = pkt[i_state.bit_count[2:0]];
                    s.bit_count = cnt_inc;
                    if (cnt_inc >= REQ_LEN) begin
                        s.phase     = PH_TRN;
                        s.bit_count = 8'd0;
                    end
                end
                PH_TRN: begin
                    s.phase     = PH_ACK;
                    s.bit_count = 8'd0;
                    s.ack_bits  = 3'd0;
                end
                PH_ACK: begin
                    ack_n                          = i_state.ack_bits;
                    ack_n[i_state.bit_count[1:0]]  = ack_n[i_state.bit_count[1:0]] | i_cmd.swdio_in;
                    s.ack_bits  = ack_n;
                    s.bit_count = cnt_inc;
                    if (cnt_inc >= ACK_LEN) begin
                        s.bit_count = 8'd0;
                        if (ack_n != ACK_OK) begin
                            s.phase = PH_ATRN;
                        end else if (i_state.held_request[1]) begin
                            s.phase      = PH_RDAT;
                            s.shift_word = 32'd0;
                            s.parity_acc = 1'b0;
                        end else begin
                            s.phase = PH_WTRN;
                        end
                    end
                end
                PH_ATRN: begin
                    if (i_state.ack_bits == ACK_WAIT && i_state.retries_left > 8'd1) begin
                        s.retries_left = i_state.retries_left - 8'd1;
                        s.phase        = PH_REQ;
                        s.bit_count    = 8'd0;
                    end else begin
                        if (i_state.ack_bits == ACK_WAIT) begin
                            s.retries_left = 8'd0;
                            s.final_status = ST_TIMEOUT;
                        end else if (i_state.ack_bits == ACK_FAULT) begin
                            s.final_status = ST_FAULT;
                        end else begin
                            s.final_status = ST_NOCONN;
                        end
                        s.phase = PH_IDLE;
                        fin     = 1'b1;
                    end
                end
                PH_RDAT: begin
                    s.shift_word = {i_cmd.swdio_in, i_state.shift_word[31:1]};
                    s.parity_acc = i_state.parity_acc ^ i_cmd.swdio_in;
                    s.bit_count  = cnt_inc;
                    if (cnt_inc >= DATA_LEN) begin
                        s.phase     = PH_RPAR;
                        s.bit_count = 8'd0;
                    end
                end
                PH_RPAR: begin
                    s.final_status = (i_state.parity_acc ^ i_cmd.swdio_in) ? ST_PARITY : ST_OK;
                    if (i_cfg.idle_cycles == 8'd0) begin
                        s.phase  = PH_IDLE;
                        fin      = 1'b1;
                        rd_valid = 1'b1;
                    end else begin
                        s.phase     = PH_IDLZ;
                        s.bit_count = 8'd0;
                    end
                end
                PH_WTRN: begin
                    s.phase      = PH_WDAT;
                    s.bit_count  = 8'd0;
                    s.parity_acc = 1'b0;
                end
                PH_WDAT: begin
                    drv          = 1'b1;
                    bit_o        = i_state.shift_word[0];
                    s.parity_acc = i_state.parity_acc ^ i_state.shift_word[0];
                    s.shift_word = {1'b0, i_state.shift_word[31:1]};
                    s.bit_count  = cnt_inc;
                    if (cnt_inc >= DATA_LEN) begin
                        s.phase     = PH_WPAR;
                        s.bit_count = 8'd0;
                    end
                end
                PH_WPAR: begin
                    drv            = 1'b1;
                    bit_o          = i_state.parity_acc;
                    s.final_status = ST_OK;
                    if (i_cfg.idle_cycles == 8'd0) begin
                        s.phase = PH_IDLE;
                        fin     = 1'b1;
                    end else begin
                        s.phase     = PH_IDLZ;
                        s.bit_count = 8'd0;
                    end
                end
                PH_IDLZ: begin
                    drv         = 1'b1;
                    s.bit_count = cnt_inc;
                    // compares against the live register value
                    if (cnt_inc >= i_cfg.idle_cycles) begin
                        s.phase  = PH_IDLE;
                        fin      = 1'b1;
                        rd_valid = i_state.held_request[1];
                    end
                end
                PH_LRST: begin
                    drv = 1'b1;
                    if (i_state.bit_count >= LRST_SEQ_LO && i_state.bit_count < LRST_SEQ_HI) begin
                        // offset from 64 is the low nibble
                        bit_o = LINE_SEQ[i_state.bit_count[3:0]];
                    end else begin
                        bit_o = 1'b1;
                    end
                    s.bit_count = cnt_inc;
                    if (cnt_inc >= LRST_LEN) begin
                        s.final_status = ST_OK;
                        s.phase        = PH_IDLE;
                        fin            = 1'b1;
                    end
                end
                default: begin
                    s.phase = PH_IDLE;
                end
            endcase
            if (fin) begin
                s.bit_count = 8'd0;
            end
        end

        o_state           = s;
        o_rsp.swdio_out   = bit_o;
        o_rsp.swdio_drive = drv;
        o_rsp.busy_res    = busy;
        o_rsp.done_res    = fin;
        o_rsp.status      = (s.phase == PH_IDLE) ? s.final_status : ST_OK;
        o_rsp.read_data   = (fin && rd_valid) ? s.shift_word : 32'd0;
    end

endmodule

[hdl/swd_host_transfer_engine_core.sv]
// Top level of the SWD host transfer engine: command/response channels, config
// registers, engine state and the response output register.
// Depends on swdh_pkg, swdh_chan_if and swdh_step.

// SWD host engine. Each command transaction (one SWCLK tick, a transfer start
// or a line-reset start) produces exactly one response transaction, in the
// cycle after it is accepted. A command is accepted every cycle as long as the
// response register is empty or being drained in that same cycle, so the
// sustained rate is one transaction per clock; only a stalled response side
// holds off commands. A transfer sends the request, a turnaround and the ack,
// then on OK the data and parity (with a turnaround first for writes) and zero
// ticks for the idle period set by idle_cycles; a non-OK ack adds a turnaround
// and WAIT resends the request, so the request goes out at most retry_limit
// times (at least once). A line reset sends ones, the select pattern, then ones.
// Configuration writes take effect on the next clock.
module swd_host_transfer_engine_core
    import swdh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    swdh_chan_if.sink   i_cmd,
    swdh_chan_if.source o_rsp
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_rsp   n_rsp;
    t_rsp   r_rsp;
    logic   r_rsp_valid;
    logic   cmd_fire;

    assign i_cmd.ready = !r_rsp_valid || o_rsp.ready;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;

    // Per-tick engine logic
    swdh_step u_step (
        .i_state (r_state),
        .i_cmd   (i_cmd.data),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_rsp   (n_rsp)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_limit <= RETRY_LIMIT_RST;
            r_cfg.idle_cycles <= IDLE_CYCLES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RETRY_LIMIT: r_cfg.retry_limit <= i_cfg_wdata;
                CFG_IDLE_CYCLES: r_cfg.idle_cycles <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Engine state advances once per accepted command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (cmd_fire) begin
            r_state <= n_state;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (cmd_fire) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    // Checks
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && r_rsp.done_res |-> r_rsp.busy_res)
        else $error("done without busy");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && r_rsp.swdio_drive |-> r_rsp.busy_res)
        else $error("line driven while not busy");

    a_status_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && r_rsp.busy_res && !r_rsp.done_res |-> r_rsp.status == ST_OK)
        else $error("status shown during an operation");

    a_rdata_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && (r_rsp.read_data != 32'd0) |-> r_rsp.done_res)
        else $error("read data outside done tick");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_fire && n_rsp.done_res |=> r_state.phase == PH_IDLE)
        else $error("engine not idle after done");

endmodule
